### design/srv_pkg.sv
// ----------------------------------------------------------------------------
// srv_pkg: shared types, constants and arithmetic helpers
// Widths, register codes, reset values and the Q15 helpers used by the
// reverb datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package srv_pkg;

  // default line lengths
  localparam int COMB_LEN_0_DEF    = 1116;
  localparam int COMB_LEN_1_DEF    = 1188;
  localparam int COMB_LEN_2_DEF    = 1277;
  localparam int COMB_LEN_3_DEF    = 1356;
  localparam int ALLPASS_LEN_0_DEF = 556;
  localparam int ALLPASS_LEN_1_DEF = 441;

  localparam int COMB_N     = 4;
  localparam int SAMPLE_W   = 24;
  localparam int OUT_W      = 25;
  localparam int LINE_W     = 16;
  localparam int GAIN_W     = 15;
  localparam int LEVEL_W    = 16;
  localparam int MIX_GAIN_W = 17;
  localparam int SUM_W      = 18;
  localparam int AP0_W      = 19;
  localparam int AP1_W      = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [MIX_GAIN_W-1:0] Q15_ONE = 17'd32768;

  localparam logic                  ENABLE_RST  = 1'b1;
  localparam logic [GAIN_W-1:0]     COMB_FB_RST = 15'd27525;
  localparam logic [GAIN_W-1:0]     AP_GAIN_RST = 15'd16384;
  localparam logic [LEVEL_W-1:0]    WET_RST     = 16'd8192;

  localparam logic signed [SAMPLE_W-1:0] LINE_MAX = 24'sd32767;
  localparam logic signed [SAMPLE_W-1:0] LINE_MIN = -24'sd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE  = 2'd0,
    REG_COMB_FB = 2'd1,
    REG_AP_GAIN = 2'd2,
    REG_WET     = 2'd3
  } srv_reg_t;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } srv_state_t;

  // strobes from the sequencer and the line stage to every delay line
  typedef struct packed {
    logic clr;
    logic rd;
    logic wb;
  } srv_tap_ctl_t;

  // word handed from the line stage to the output mix
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] dry;
    logic signed [AP1_W-1:0]    ap;
    logic                       block_end;
    logic                       en;
  } srv_mix_t;

  function automatic logic signed [LINE_W-1:0] clip16(input logic signed [SAMPLE_W-1:0] v);
    logic signed [LINE_W-1:0] r;
    if (v > LINE_MAX) begin
      r = LINE_MAX[LINE_W-1:0];
    end else if (v < LINE_MIN) begin
      r = LINE_MIN[LINE_W-1:0];
    end else begin
      r = v[LINE_W-1:0];
    end
    return r;
  endfunction

  // floor(d * g / 2^15); the product fits 31 bits, the result 16
  function automatic logic signed [LINE_W-1:0] mul_q15(input logic signed [LINE_W-1:0] d,
                                                       input logic [GAIN_W-1:0] g);
    logic signed [LINE_W+GAIN_W-1:0] p;
    p = (LINE_W + GAIN_W)'(d) * (LINE_W + GAIN_W)'($signed({1'b0, g}));
    return p[LINE_W+GAIN_W-1:GAIN_W];
  endfunction

endpackage

`default_nettype wire

### design/srv_if.sv
// ----------------------------------------------------------------------------
// srv_if: stream channels of the reverb
// Input channel carries the dry sample and block flag, output channel
// carries the reverberated sample and block flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface srv_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [srv_pkg::SAMPLE_W-1:0]      sample_in;
  logic                                     block_end;

  modport source (output valid, output sample_in, output block_end, input ready);
  modport sink   (input valid, input sample_in, input block_end, output ready);
endinterface

interface srv_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [srv_pkg::OUT_W-1:0]         sample_out;
  logic                                     block_end_out;

  modport source (output valid, output sample_out, output block_end_out, input ready);
  modport sink   (input valid, input sample_out, input block_end_out, output ready);
endinterface

`default_nettype wire

### design/srv_ram.sv
// ----------------------------------------------------------------------------
// srv_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module srv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/srv_tap.sv
// ----------------------------------------------------------------------------
// srv_tap: one circular delay line
// Holds the line position, reads the delayed word at the position when an
// item enters and writes the new word back to the same entry one stage
// later. Takes zero writes from the clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module srv_tap #(
  parameter int LEN   = 1024,
  parameter int CLR_W = 11
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  srv_pkg::srv_tap_ctl_t                 ctl,
  input  logic [CLR_W-1:0]                      clr_addr,
  input  logic signed [srv_pkg::LINE_W-1:0]     wb_data,
  output logic signed [srv_pkg::LINE_W-1:0]     rd_data
);
  import srv_pkg::*;

  localparam int AW = $clog2(LEN);

  logic [AW-1:0]     pos;
  logic [AW-1:0]     pos_wb;
  logic              clr_hit;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [LINE_W-1:0] wdata;
  logic [LINE_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (ctl.rd) begin
      pos <= (pos == AW'(LEN - 1)) ? '0 : pos + 1'b1;
    end
  end

  // remember the entry in flight for the write-back
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      pos_wb <= pos;
    end
  end

  assign clr_hit = ({1'b0, clr_addr} < (CLR_W + 1)'(LEN));
  assign we      = (ctl.clr && clr_hit) || ctl.wb;
  assign waddr   = ctl.clr ? clr_addr[AW-1:0] : pos_wb;
  assign wdata   = ctl.clr ? '0 : wb_data;
  assign rd_data = $signed(rdata);

  srv_ram #(
    .WIDTH (LINE_W),
    .DEPTH (LEN)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctl.rd),
    .raddr (pos),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

### design/srv_mix.sv
// ----------------------------------------------------------------------------
// srv_mix: dry/wet mix and output register
// A holding stage takes the allpass result, then the two Q15 products are
// summed into the output register, which parts the pipeline from the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module srv_mix (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  srv_pkg::srv_mix_t                  word,
  input  logic [srv_pkg::MIX_GAIN_W-1:0]     dry_gain,
  input  logic [srv_pkg::MIX_GAIN_W-1:0]     wet_gain,
  output logic                               free,
  srv_out_if.source                          dout
);
  import srv_pkg::*;

  localparam int PD_W = SAMPLE_W + MIX_GAIN_W + 1;
  localparam int PW_W = AP1_W + MIX_GAIN_W + 1;

  logic                           s2_valid;
  srv_mix_t                       s2;
  logic                           out_take;
  logic signed [MIX_GAIN_W:0]     dry_s;
  logic signed [MIX_GAIN_W:0]     wet_s;
  logic signed [PD_W-1:0]         prod_d;
  logic signed [PW_W-1:0]         prod_w;
  logic [OUT_W-1:0]               mix_sum;
  logic [OUT_W-1:0]               result;

  assign out_take = !dout.valid || dout.ready;
  assign free     = !s2_valid || out_take;

  assign dry_s   = $signed({1'b0, dry_gain});
  assign wet_s   = $signed({1'b0, wet_gain});
  assign prod_d  = PD_W'(s2.dry) * PD_W'(dry_s);
  assign prod_w  = PW_W'(s2.ap) * PW_W'(wet_s);
  // wrap to the output width; the floor shift is the part-select
  assign mix_sum = prod_d[OUT_W+GAIN_W-1:GAIN_W]
                 + OUT_W'($signed(prod_w[PW_W-1:GAIN_W]));
  assign result  = s2.en ? mix_sum : OUT_W'(s2.dry);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid   <= 1'b0;
      dout.valid <= 1'b0;
    end else begin
      if (free) begin
        s2_valid <= push;
      end
      if (out_take) begin
        dout.valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && free) begin
      s2 <= word;
    end
    if (out_take && s2_valid) begin
      dout.sample_out    <= $signed(result);
      dout.block_end_out <= s2.block_end;
    end
  end

endmodule

`default_nettype wire

### design/schroeder_reverb_q15_unit.sv
// ----------------------------------------------------------------------------
// schroeder_reverb_q15_unit: four-comb, two-allpass Q15 reverb
// Six delay lines in block RAM, read when a word enters and written back
// one stage later; the dry/wet mix follows in a registered output stage.
//
//   channel   dir  payload                         handshake
//   din       in   sample_in[23:0], block_end      valid/ready
//   dout      out  sample_out[24:0], block_end_out valid/ready
//   cfg       in   cfg_index[1:0], cfg_data[15:0]  cfg_wr_en
//
// One word per cycle sustained while dout is ready; a word passes the line
// stage, the holding stage and the output register. The RAM read-modify-write
// of each line closes in one stage, so a line entry is always written back
// before it is read again. After reset a clearing sweep zeroes all lines, one
// entry per cycle, over as many entries as the longest line (1356 at the
// default lengths); din ready stays low meanwhile. A stalled dout holds its
// word while up to two more words enter.
// ----------------------------------------------------------------------------
`default_nettype none

module schroeder_reverb_q15_unit #(
  parameter int COMB_LEN_0    = srv_pkg::COMB_LEN_0_DEF,
  parameter int COMB_LEN_1    = srv_pkg::COMB_LEN_1_DEF,
  parameter int COMB_LEN_2    = srv_pkg::COMB_LEN_2_DEF,
  parameter int COMB_LEN_3    = srv_pkg::COMB_LEN_3_DEF,
  parameter int ALLPASS_LEN_0 = srv_pkg::ALLPASS_LEN_0_DEF,
  parameter int ALLPASS_LEN_1 = srv_pkg::ALLPASS_LEN_1_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [srv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srv_pkg::CFG_DATA_W-1:0]     cfg_data,
  srv_in_if.sink                             din,
  srv_out_if.source                          dout
);
  import srv_pkg::*;

  localparam int COMB_LEN [COMB_N] = '{COMB_LEN_0, COMB_LEN_1, COMB_LEN_2, COMB_LEN_3};
  localparam int MAX_C01  = (COMB_LEN_0 > COMB_LEN_1) ? COMB_LEN_0 : COMB_LEN_1;
  localparam int MAX_C23  = (COMB_LEN_2 > COMB_LEN_3) ? COMB_LEN_2 : COMB_LEN_3;
  localparam int MAX_C    = (MAX_C01 > MAX_C23) ? MAX_C01 : MAX_C23;
  localparam int MAX_A    = (ALLPASS_LEN_0 > ALLPASS_LEN_1) ? ALLPASS_LEN_0 : ALLPASS_LEN_1;
  localparam int MAX_LEN  = (MAX_C > MAX_A) ? MAX_C : MAX_A;
  localparam int CLR_W    = $clog2(MAX_LEN);

  // configuration
  logic                  enable;
  logic [GAIN_W-1:0]     comb_feedback;
  logic [GAIN_W-1:0]     allpass_gain;
  logic [LEVEL_W-1:0]    wet_level;
  logic [MIX_GAIN_W-1:0] wet_gain;
  logic [MIX_GAIN_W-1:0] dry_gain;

  // clearing sequencer
  srv_state_t            state;
  srv_state_t            state_next;
  logic [CLR_W-1:0]      clr_cnt;
  logic                  clr_active;
  logic                  running;

  // line stage
  logic                      accept;
  logic                      s1_valid;
  logic signed [SAMPLE_W-1:0] s1_dry;
  logic                      s1_be;
  logic                      s1_en;
  logic                      s1_move;
  logic                      s1_free;
  logic                      s2_free;
  srv_tap_ctl_t              tap_ctl;
  srv_mix_t                  mix_word;

  logic signed [LINE_W-1:0]  comb_d   [COMB_N];
  logic signed [LINE_W-1:0]  comb_wb  [COMB_N];
  logic signed [LINE_W-1:0]  comb_p   [COMB_N];
  logic signed [LINE_W:0]    comb_acc [COMB_N];
  logic signed [LINE_W-1:0]  ap0_d;
  logic signed [LINE_W-1:0]  ap1_d;
  logic signed [LINE_W-1:0]  ap0_wb;
  logic signed [LINE_W-1:0]  ap1_wb;
  logic signed [LINE_W-1:0]  x;
  logic signed [SUM_W-1:0]   comb_total;
  logic signed [LINE_W-1:0]  ap0_p;
  logic signed [LINE_W-1:0]  ap1_p;
  logic signed [AP0_W-1:0]   ap0_acc;
  logic signed [AP0_W-1:0]   ap0_out;
  logic signed [AP1_W-1:0]   ap1_acc;
  logic signed [AP1_W-1:0]   ap1_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= ENABLE_RST;
      comb_feedback <= COMB_FB_RST;
      allpass_gain  <= AP_GAIN_RST;
      wet_level     <= WET_RST;
    end else if (cfg_wr_en) begin
      case (srv_reg_t'(cfg_index))
        REG_ENABLE:  enable        <= cfg_data[0];
        REG_COMB_FB: comb_feedback <= cfg_data[GAIN_W-1:0];
        REG_AP_GAIN: allpass_gain  <= cfg_data[GAIN_W-1:0];
        REG_WET:     wet_level     <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate wet above unity
  assign wet_gain = ({1'b0, wet_level} > Q15_ONE) ? Q15_ONE : {1'b0, wet_level};
  assign dry_gain = Q15_ONE - wet_gain;

  // clearing sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clr_active) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == CLR_W'(MAX_LEN - 1)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN:  state_next = ST_RUN;
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_active = 1'b0;
    running    = 1'b0;
    case (state)
      ST_CLEAR: clr_active = 1'b1;
      ST_RUN:   running    = 1'b1;
      default: ;
    endcase
  end

  // handshake of the line stage
  assign s1_move    = s1_valid && s2_free;
  assign s1_free    = !s1_valid || s2_free;
  assign din.ready  = running && s1_free;
  assign accept     = din.valid && din.ready;

  assign tap_ctl.clr = clr_active;
  assign tap_ctl.rd  = accept && enable;
  assign tap_ctl.wb  = s1_move && s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_dry <= din.sample_in;
      s1_be  <= din.block_end;
      s1_en  <= enable;
    end
  end

  // line arithmetic: write-back words for all six lines and the allpass output
  always_comb begin
    x = clip16(s1_dry);
    for (int i = 0; i < COMB_N; i++) begin
      comb_p[i]   = mul_q15(comb_d[i], comb_feedback);
      comb_acc[i] = (LINE_W + 1)'(x) + (LINE_W + 1)'(comb_p[i]);
      comb_wb[i]  = clip16(SAMPLE_W'(comb_acc[i]));
    end
    comb_total = SUM_W'(comb_d[0]) + SUM_W'(comb_d[1])
               + SUM_W'(comb_d[2]) + SUM_W'(comb_d[3]);
    ap0_p    = mul_q15(ap0_d, allpass_gain);
    ap1_p    = mul_q15(ap1_d, allpass_gain);
    ap0_acc  = AP0_W'(comb_total) + AP0_W'(ap0_p);
    ap0_wb   = clip16(SAMPLE_W'(ap0_acc));
    ap0_out  = AP0_W'(ap0_d) - AP0_W'(comb_total);
    ap1_acc  = AP1_W'(ap0_out) + AP1_W'(ap1_p);
    ap1_wb   = clip16(SAMPLE_W'(ap1_acc));
    ap1_out  = AP1_W'(ap1_d) - AP1_W'(ap0_out);
  end

  for (genvar g = 0; g < COMB_N; g++) begin : g_comb
    srv_tap #(
      .LEN   (COMB_LEN[g]),
      .CLR_W (CLR_W)
    ) u_comb (
      .clk      (clk),
      .rst      (rst),
      .ctl      (tap_ctl),
      .clr_addr (clr_cnt),
      .wb_data  (comb_wb[g]),
      .rd_data  (comb_d[g])
    );
  end

  srv_tap #(
    .LEN   (ALLPASS_LEN_0),
    .CLR_W (CLR_W)
  ) u_ap0 (
    .clk      (clk),
    .rst      (rst),
    .ctl      (tap_ctl),
    .clr_addr (clr_cnt),
    .wb_data  (ap0_wb),
    .rd_data  (ap0_d)
  );

  srv_tap #(
    .LEN   (ALLPASS_LEN_1),
    .CLR_W (CLR_W)
  ) u_ap1 (
    .clk      (clk),
    .rst      (rst),
    .ctl      (tap_ctl),
    .clr_addr (clr_cnt),
    .wb_data  (ap1_wb),
    .rd_data  (ap1_d)
  );

  assign mix_word.dry       = s1_dry;
  assign mix_word.ap        = ap1_out;
  assign mix_word.block_end = s1_be;
  assign mix_word.en        = s1_en;

  srv_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .push     (s1_move),
    .word     (mix_word),
    .dry_gain (dry_gain),
    .wet_gain (wet_gain),
    .free     (s2_free),
    .dout     (dout)
  );

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream check of the four-comb, two-allpass Q15 reverb
// A model of the comb and allpass delay lines runs beside the unit and
// predicts every output word from the words taken in. Stimulus covers sample
// extremes, pass-through, register masking and wet levels above unity, under
// several mixes of source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import srv_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int PHASE_COUNT     = 8;
  localparam int WORDS_PER_PHASE = 242;
  localparam int LINE_COUNT      = 6;
  localparam int LINE_SLOTS      = 2048;
  localparam int AP_SLOT_0       = 4;
  localparam int AP_SLOT_1       = 5;

  typedef struct packed {
    logic [OUT_W-1:0] sample;
    logic             flag;
  } out_word_t;

  // Delay-line model of the reverb plus the queue of words it still owes.
  class reverb_model;
    shortint   line_mem[LINE_COUNT][LINE_SLOTS];
    int        line_len[LINE_COUNT];
    int        line_pos[LINE_COUNT];
    bit        en;
    longint    comb_fb;
    longint    ap_gain;
    longint    wet_lvl;
    out_word_t owed[$];
    int        mismatches;

    function new();
      line_len = '{COMB_LEN_0_DEF, COMB_LEN_1_DEF, COMB_LEN_2_DEF, COMB_LEN_3_DEF,
                   ALLPASS_LEN_0_DEF, ALLPASS_LEN_1_DEF};
      foreach (line_pos[k]) line_pos[k] = 0;
      en         = ENABLE_RST;
      comb_fb    = COMB_FB_RST;
      ap_gain    = AP_GAIN_RST;
      wet_lvl    = WET_RST;
      mismatches = 0;
    endfunction

    function void write_reg(srv_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_ENABLE:  en = v[0];
        REG_COMB_FB: comb_fb = v[GAIN_W-1:0];
        REG_AP_GAIN: ap_gain = v[GAIN_W-1:0];
        REG_WET:     wet_lvl = v;
        default: ;
      endcase
    endfunction

    function longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // floor(a * b / 2^15)
    function longint q15_scale(longint a, longint b);
      return (a * b) >>> 15;
    endfunction

    // read the delayed entry, write back x plus scaled feedback, advance
    function longint tap(int k, longint x, longint g);
      longint d;
      d = line_mem[k][line_pos[k]];
      line_mem[k][line_pos[k]] = shortint'(sat16(x + q15_scale(d, g)));
      line_pos[k] = (line_pos[k] + 1 >= line_len[k]) ? 0 : line_pos[k] + 1;
      return d;
    endfunction

    function void note_input(logic signed [SAMPLE_W-1:0] s, logic flag);
      longint    dry;
      longint    x;
      longint    sum;
      longint    ap;
      longint    wet;
      longint    res;
      out_word_t w;
      dry = s;
      if (en) begin
        x   = sat16(dry);
        wet = (wet_lvl > longint'(Q15_ONE)) ? longint'(Q15_ONE) : wet_lvl;
        sum = 0;
        for (int k = 0; k < COMB_N; k++) sum += tap(k, x, comb_fb);
        ap  = tap(AP_SLOT_0, sum, ap_gain) - sum;
        ap  = tap(AP_SLOT_1, ap, ap_gain) - ap;
        res = q15_scale(dry, longint'(Q15_ONE) - wet) + q15_scale(ap, wet);
      end else begin
        res = dry;
      end
      w.sample = res[OUT_W-1:0];
      w.flag   = flag;
      owed.push_back(w);
    endfunction

    function void check_output(logic [OUT_W-1:0] s, logic flag);
      out_word_t w;
      if (owed.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word sample_out %0d block_end_out %0b",
                 $time, $signed(s), flag);
        return;
      end
      w = owed.pop_front();
      if (s !== w.sample) begin
        mismatches++;
        $display("%0t: sample_out expected %0d got %0d",
                 $time, $signed(w.sample), $signed(s));
      end
      if (flag !== w.flag) begin
        mismatches++;
        $display("%0t: block_end_out expected %0b got %0b", $time, w.flag, flag);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  srv_in_if  din();
  srv_out_if dout();

  reverb_model rv;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int cycle_count    = 0;

  schroeder_reverb_q15_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din),
    .dout      (dout)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    dout.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (din.valid && din.ready) rv.note_input(din.sample_in, din.block_end);
      if (dout.valid && dout.ready) rv.check_output(dout.sample_out, dout.block_end_out);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // hold the word until the handshake edge, with random gaps ahead of it
  task automatic send_word(input logic [SAMPLE_W-1:0] s, input logic flag);
    while ($urandom_range(99) < src_idle_pct) begin
      din.valid <= 1'b0;
      @(posedge clk);
    end
    din.valid     <= 1'b1;
    din.sample_in <= s;
    din.block_end <= flag;
    do @(posedge clk); while (!din.ready);
  endtask

  task automatic drain();
    din.valid <= 1'b0;
    do @(posedge clk); while (rv.owed.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input logic [CFG_DATA_W-1:0] en_v, fb_v, ap_v, wet_v);
    srv_reg_t              idx[4]  = '{REG_ENABLE, REG_COMB_FB, REG_AP_GAIN, REG_WET};
    logic [CFG_DATA_W-1:0] vals[4];
    vals = '{en_v, fb_v, ap_v, wet_v};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      rv.write_reg(idx[i], vals[i]);
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned           r;
    logic [15:0]           s16;
    logic [SAMPLE_W-1:0]   v;
    r = $urandom_range(99);
    if (r < 10) begin
      case ($urandom_range(5))
        0:       v = 24'h7FFFFF;
        1:       v = 24'h800000;
        2:       v = 24'sd32768;
        3:       v = -24'sd32769;
        4:       v = 24'sd32767;
        default: v = -24'sd32768;
      endcase
    end else if (r < 35) begin
      v = SAMPLE_W'($urandom);
    end else if (r < 80) begin
      s16 = 16'($urandom);
      v   = {{8{s16[15]}}, s16};
    end else begin
      v = SAMPLE_W'($urandom_range(512) - 256);
    end
    return v;
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] en_v;
    logic [CFG_DATA_W-1:0] fb_v;
    logic [CFG_DATA_W-1:0] ap_v;
    logic [CFG_DATA_W-1:0] wet_v;
    rv = new();
    din.valid     <= 1'b0;
    din.sample_in <= '0;
    din.block_end <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= REG_ENABLE;
    cfg_data      <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: sample extremes, clip edges and bit patterns
    send_word(24'sd0, 1'b0);
    send_word(24'h7FFFFF, 1'b1);
    send_word(24'h800000, 1'b0);
    send_word(24'sd32767, 1'b0);
    send_word(24'sd32768, 1'b1);
    send_word(-24'sd32768, 1'b0);
    send_word(-24'sd32769, 1'b0);
    send_word(24'sd1, 1'b1);
    send_word(-24'sd1, 1'b0);
    send_word(24'h555555, 1'b0);
    send_word(24'hAAAAAA, 1'b1);
    repeat (6) send_word(24'h7FFFFF, 1'b0);
    repeat (6) send_word(24'h800000, 1'b0);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph != 0) begin
        drain();
        case (ph)
          1: begin en_v = 16'd1; fb_v = 16'd32767; ap_v = 16'd32767; wet_v = 16'd32768; end
          2: begin
            en_v = 16'd0; fb_v = CFG_DATA_W'($urandom); ap_v = CFG_DATA_W'($urandom);
            wet_v = CFG_DATA_W'($urandom);
          end
          3: begin en_v = 16'd1; fb_v = 16'd0; ap_v = 16'd0; wet_v = 16'd0; end
          // bit 15 of the gains is dropped; wet above unity leaves no dry part
          4: begin en_v = 16'd1; fb_v = 16'hFFFF; ap_v = 16'h8000; wet_v = 16'hFFFF; end
          5: begin
            en_v = 16'd1; fb_v = CFG_DATA_W'($urandom); ap_v = CFG_DATA_W'($urandom);
            wet_v = CFG_DATA_W'($urandom_range(32768));
          end
          6: begin en_v = 16'd1; fb_v = 16'd32767; ap_v = 16'd0; wet_v = 16'd40000; end
          default: begin
            en_v = 16'd1; fb_v = CFG_DATA_W'($urandom); ap_v = CFG_DATA_W'($urandom);
            wet_v = CFG_DATA_W'($urandom);
          end
        endcase
        apply_config(en_v, fb_v, ap_v, wet_v);
      end
      case (ph % 4)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 45; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 45; end
        default: begin src_idle_pct = 37; sink_stall_pct = 37; end
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // hold off mid-phase until the pipe is empty, then resume
        if (ph == 5 && n == WORDS_PER_PHASE / 2) drain();
        send_word(pick_sample(), $urandom_range(15) == 0);
      end
    end

    drain();
    if (rv.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
